@@ design/type_length_message_deframer_defines.svh @@
`ifndef TYPE_LENGTH_MESSAGE_DEFRAMER_DEFINES_SVH
`define TYPE_LENGTH_MESSAGE_DEFRAMER_DEFINES_SVH

// Concurrent check on clk_i, off while reset is held.
`define TLMD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Concurrent check on clk_i that also holds during reset.
`define TLMD_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ design/tlmd_pkg.sv @@
package tlmd_pkg;

  // Message store size and parsed-message counter width
  localparam int STORE_DEPTH = 32;
  localparam int COUNT_WIDTH = 16;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Header fields
  localparam int TYPE_W = 3;
  localparam int LEN_W  = 5;

  // Reported count width and its ceiling
  localparam int              REP_COUNT_W   = 16;
  localparam logic [31:0]     REP_COUNT_MAX = 32'h0000_FFFF;

  // Register reset values
  localparam logic [LEN_W-1:0] MAX_LENGTH_RST     = 5'h1F;
  localparam logic [7:0]       HANDLER_ENABLE_RST = 8'hFF;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_MAX_LENGTH     = 1'b0,
    CFG_HANDLER_ENABLE = 1'b1
  } cfg_index_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_e;

  // Buffer status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_TOO_LONG  = 2'd1,
    STAT_TRUNCATED = 2'd2
  } status_e;

  // Clip a counter value to the reported width
  function automatic logic [REP_COUNT_W-1:0] clip_count(input logic [31:0] cnt);
    logic [REP_COUNT_W-1:0] res;
    if (cnt > REP_COUNT_MAX) begin
      res = REP_COUNT_MAX[REP_COUNT_W-1:0];
    end else begin
      res = cnt[REP_COUNT_W-1:0];
    end
    return res;
  endfunction

endpackage

@@ design/tlmd_ram.sv @@
module tlmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // One write port, one registered read port; read data holds without rd_en
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ design/type_length_message_deframer.sv @@
// Type/length message deframer. Input beats carry one byte each; tlast marks
// the final byte of a buffer. Each message is a header byte (type in bits
// 7..5, length in bits 4..0) and then that many payload bytes, which are
// written into a 32-entry message store. A completed message whose type is
// enabled in handler_enable is read back from the store and sent as one beat
// per payload byte (tuser = payload), or as one empty-message beat when its
// length is zero; the last byte of a buffer adds a status beat with the
// message count, or an error code (length over max_length, or buffer ended
// inside a message). After a length error the rest of the buffer is dropped.
// Timing: a byte that gives no result leaves the input ready, so plain payload
// bytes stream at one per cycle. A byte that completes an enabled message
// first takes one store read to prime the single read port, then sends one
// beat per cycle for its N payload bytes; an empty message or a status beat
// adds one beat each; all of this stretches with back-pressure on the output.
// The input is not ready while a message or status is being sent. The output
// beat sits in a register, so the input takes new bytes while it waits.
// Configuration writes are always ready and take effect on the next byte.
module type_length_message_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,     // 0 max_length, 1 handler_enable
  input  logic [7:0]  cfg_data_i,
  // Byte input
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] in_byte
  input  logic        s_axis_tlast_i,  // end_of_buffer
  // Result output
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [2:0] msg_type, [10:3] payload_byte, [15:11] byte_index,
  // [20:16] msg_length, [22:21] status_code, [38:23] message_count, [39] zero
  output logic [39:0] m_axis_tdata_o,
  output logic [1:0]  m_axis_tuser_o,  // [1:0] kind
  output logic        m_axis_tlast_o   // last
);

  import tlmd_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_SKIP
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SEND,
    ST_EMPTY,
    ST_STATUS
  } state_e;

  // Registers
  state_e                   state_q;
  phase_e                   phase_q;
  logic [LEN_W-1:0]         max_len_q;
  logic [7:0]               enable_q;
  logic [TYPE_W-1:0]        cur_type_q;
  logic [LEN_W-1:0]         cur_len_q;
  logic [ADDR_W-1:0]        rcv_q;
  logic [COUNT_WIDTH-1:0]   parsed_q;
  logic [TYPE_W-1:0]        rep_type_q;
  logic [LEN_W-1:0]         rep_len_q;
  logic [ADDR_W-1:0]        rd_idx_q;
  logic                     eob_q;
  status_e                  stat_code_q;
  logic [REP_COUNT_W-1:0]   stat_count_q;

  logic                     out_valid_q;
  kind_e                    out_kind_q;
  logic [TYPE_W-1:0]        out_type_q;
  logic [7:0]               out_byte_q;
  logic [ADDR_W-1:0]        out_idx_q;
  logic [LEN_W-1:0]         out_len_q;
  status_e                  out_code_q;
  logic [REP_COUNT_W-1:0]   out_count_q;
  logic                     out_last_q;

  // Parser next values
  phase_e                   phase_d;
  logic [TYPE_W-1:0]        cur_type_d;
  logic [LEN_W-1:0]         cur_len_d;
  logic [ADDR_W-1:0]        rcv_d;
  logic [COUNT_WIDTH-1:0]   parsed_d;
  logic                     emp_msg;
  logic                     rep_msg;
  status_e                  stat_code_d;

  logic                     in_fire;
  logic                     slot_free;
  logic                     out_load;
  logic [TYPE_W-1:0]        hdr_type;
  logic [LEN_W-1:0]         hdr_len;
  logic                     idx_final;

  logic                     st_wr_en;
  logic                     st_rd_en;
  logic [ADDR_W-1:0]        st_rd_addr;
  logic [7:0]               st_rd_data;

  // Assertion helpers
  logic                     beat_status;
  logic                     beat_payload;
  logic                     in_payload;
  logic                     eob_fire;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free       = !out_valid_q || m_axis_tready_i;
  assign out_load        = slot_free && ((state_q == ST_SEND) || (state_q == ST_EMPTY) ||
                                         (state_q == ST_STATUS));
  assign hdr_type        = s_axis_tdata_i[7:5];
  assign hdr_len         = s_axis_tdata_i[4:0];
  assign idx_final       = ({1'b0, rd_idx_q} + 6'd1) == {1'b0, rep_len_q};

  // Header / payload parsing of the accepted byte
  always_comb begin
    logic             cnt_inc;
    logic [ADDR_W-1:0] rcv_inc;
    phase_d    = phase_q;
    cur_type_d = cur_type_q;
    cur_len_d  = cur_len_q;
    rcv_d      = rcv_q;
    emp_msg    = 1'b0;
    rep_msg    = 1'b0;
    cnt_inc    = 1'b0;
    rcv_inc    = rcv_q + ADDR_W'(1);
    case (phase_q)
      PH_HEADER: begin
        if (hdr_len > max_len_q) begin
          phase_d = PH_SKIP;
        end else if (hdr_len == '0) begin
          cnt_inc = 1'b1;
          emp_msg = enable_q[hdr_type];
        end else begin
          cur_type_d = hdr_type;
          cur_len_d  = hdr_len;
          rcv_d      = '0;
          phase_d    = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (rcv_inc == cur_len_q) begin
          cnt_inc = 1'b1;
          rep_msg = enable_q[cur_type_q];
          phase_d = PH_HEADER;
          rcv_d   = '0;
        end else begin
          rcv_d = rcv_inc;
        end
      end
      default: begin
        phase_d = PH_SKIP;
      end
    endcase
    // Saturating message counter
    if (cnt_inc && (parsed_q != '1)) begin
      parsed_d = parsed_q + COUNT_WIDTH'(1);
    end else begin
      parsed_d = parsed_q;
    end
    // Buffer status from the phase this byte leaves behind
    case (phase_d)
      PH_SKIP:    stat_code_d = STAT_TOO_LONG;
      PH_PAYLOAD: stat_code_d = STAT_TRUNCATED;
      default:    stat_code_d = STAT_OK;
    endcase
  end

  // Store ports: payload written at accept, read back only in later cycles,
  // so a read never meets a write to the same entry
  assign st_wr_en   = in_fire && (phase_q == PH_PAYLOAD);
  assign st_rd_en   = (state_q == ST_READ) ||
                      ((state_q == ST_SEND) && slot_free && !idx_final);
  assign st_rd_addr = (state_q == ST_READ) ? rd_idx_q : rd_idx_q + ADDR_W'(1);

  tlmd_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (st_wr_en),
    .wr_addr_i (rcv_q),
    .wr_data_i (s_axis_tdata_i),
    .rd_en_i   (st_rd_en),
    .rd_addr_i (st_rd_addr),
    .rd_data_o (st_rd_data)
  );

  // Sequencer, parser state, registers and output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      phase_q      <= PH_HEADER;
      max_len_q    <= MAX_LENGTH_RST;
      enable_q     <= HANDLER_ENABLE_RST;
      cur_type_q   <= '0;
      cur_len_q    <= '0;
      rcv_q        <= '0;
      parsed_q     <= '0;
      rep_type_q   <= '0;
      rep_len_q    <= '0;
      rd_idx_q     <= '0;
      eob_q        <= 1'b0;
      stat_code_q  <= STAT_OK;
      stat_count_q <= '0;
      out_valid_q  <= 1'b0;
      out_kind_q   <= KIND_PAYLOAD;
      out_type_q   <= '0;
      out_byte_q   <= '0;
      out_idx_q    <= '0;
      out_len_q    <= '0;
      out_code_q   <= STAT_OK;
      out_count_q  <= '0;
      out_last_q   <= 1'b0;
    end else begin
      // Configuration writes
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_MAX_LENGTH:     max_len_q <= cfg_data_i[LEN_W-1:0];
          CFG_HANDLER_ENABLE: enable_q  <= cfg_data_i;
          default:            ;
        endcase
      end

      // Output register drains unless a new beat is loaded
      if (m_axis_tready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            eob_q        <= s_axis_tlast_i;
            stat_code_q  <= stat_code_d;
            stat_count_q <= clip_count(32'(parsed_d));
            rep_type_q   <= rep_msg ? cur_type_q : hdr_type;
            rep_len_q    <= cur_len_q;
            rd_idx_q     <= '0;
            if (s_axis_tlast_i) begin
              phase_q    <= PH_HEADER;
              cur_type_q <= '0;
              cur_len_q  <= '0;
              rcv_q      <= '0;
              parsed_q   <= '0;
            end else begin
              phase_q    <= phase_d;
              cur_type_q <= cur_type_d;
              cur_len_q  <= cur_len_d;
              rcv_q      <= rcv_d;
              parsed_q   <= parsed_d;
            end
            if (rep_msg) begin
              state_q <= ST_READ;
            end else if (emp_msg) begin
              state_q <= ST_EMPTY;
            end else if (s_axis_tlast_i) begin
              state_q <= ST_STATUS;
            end
          end
        end
        ST_READ: begin
          state_q <= ST_SEND;
        end
        ST_SEND: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= KIND_PAYLOAD;
            out_type_q  <= rep_type_q;
            out_byte_q  <= st_rd_data;
            out_idx_q   <= rd_idx_q;
            out_len_q   <= rep_len_q;
            out_code_q  <= STAT_OK;
            out_count_q <= '0;
            out_last_q  <= idx_final && !eob_q;
            if (idx_final) begin
              state_q <= eob_q ? ST_STATUS : ST_IDLE;
            end else begin
              rd_idx_q <= rd_idx_q + ADDR_W'(1);
            end
          end
        end
        ST_EMPTY: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= KIND_EMPTY;
            out_type_q  <= rep_type_q;
            out_byte_q  <= '0;
            out_idx_q   <= '0;
            out_len_q   <= '0;
            out_code_q  <= STAT_OK;
            out_count_q <= '0;
            out_last_q  <= !eob_q;
            state_q     <= eob_q ? ST_STATUS : ST_IDLE;
          end
        end
        ST_STATUS: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= KIND_STATUS;
            out_type_q  <= '0;
            out_byte_q  <= '0;
            out_idx_q   <= '0;
            out_len_q   <= '0;
            out_code_q  <= stat_code_q;
            out_count_q <= (stat_code_q == STAT_OK) ? stat_count_q : '0;
            out_last_q  <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {1'b0, out_count_q, out_code_q, out_len_q, out_idx_q,
                            out_byte_q, out_type_q};

  assign beat_status  = m_axis_tvalid_o && (out_kind_q == KIND_STATUS);
  assign beat_payload = m_axis_tvalid_o && (out_kind_q == KIND_PAYLOAD);
  assign in_payload   = (phase_q == PH_PAYLOAD);
  assign eob_fire     = in_fire && s_axis_tlast_i;

`include "type_length_message_deframer_defines.svh"

  // A status beat always closes the results of its byte
  `TLMD_ASSERT(a_status_last, beat_status |-> out_last_q, "status beat without last")
  // A payload beat lies inside its message
  `TLMD_ASSERT(a_payload_idx, beat_payload |-> (out_idx_q < out_len_q), "index beyond length")
  // Receive position stays inside the current message
  `TLMD_ASSERT_ALWAYS(a_rcv_range, in_payload |-> (rcv_q < cur_len_q), "rcv_q past cur_len_q")
  // A buffer end returns the parser to a clean header phase
  `TLMD_ASSERT(a_eob_clear, eob_fire |=> (!in_payload && phase_q == PH_HEADER), "not clean")
  `TLMD_ASSERT(a_eob_count, eob_fire |=> (parsed_q == '0), "count kept at buffer end")

endmodule
